[hdl/tcfst_pkg.sv]
// ----------------------------------------------------------------------------
// tcfst_pkg
// Types and constants for the TCP flow congestion statistics table.
// ----------------------------------------------------------------------------
package tcfst_pkg;

  localparam int unsigned TABLE_ENTRIES_DEF = 64;
  localparam int unsigned NUM_STATES        = 5;

  localparam int unsigned ADDR_W   = 32;
  localparam int unsigned PORT_W   = 16;
  localparam int unsigned STATE_W  = 3;
  localparam int unsigned LEN_W    = 16;
  localparam int unsigned STATUS_W = 2;
  localparam int unsigned OSLOT_W  = 6;
  localparam int unsigned COUNT_W  = 32;
  localparam int unsigned BYTES_W  = 48;
  localparam int unsigned KEY_W    = 2 * ADDR_W + 2 * PORT_W;

  localparam int unsigned IN_TDATA_W  = 120;
  localparam int unsigned OUT_TDATA_W = 88;
  localparam int unsigned OUT_TUSER_W = 3;

  localparam logic [STATE_W-1:0] MAX_STATE = 3'd4;
  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;
  localparam logic [BYTES_W-1:0] BYTES_MAX = '1;

  typedef enum logic [STATUS_W-1:0] {
    STATUS_UPDATED  = 2'd0,
    STATUS_INSERTED = 2'd1,
    STATUS_DROPPED  = 2'd2
  } status_e;

  // per-slot word: byte total, last state and a mask of counters written
  // since the slot was filled
  typedef struct packed {
    logic [NUM_STATES-1:0] live;
    logic [STATE_W-1:0]    last_state;
    logic [BYTES_W-1:0]    bytes;
  } flow_word_t;

endpackage

[hdl/tcp_flow_congestion_stats_table.sv]
// ----------------------------------------------------------------------------
// tcp_flow_congestion_stats_table
// Per-flow congestion state counters and byte totals, FIFO replacement.
// ----------------------------------------------------------------------------
// Packets enter on the s_axis channel, one item each; every packet gives one
// result item on m_axis. tuser of the input is the tracked flag. Untracked
// packets and packets with a state above 4 return status "dropped" with all
// other fields zero and leave the table alone.
// Flow keys sit in flip-flops and are compared in parallel; per-slot byte
// totals and per-state counters sit in two synchronous RAMs that take one
// read-modify-write per packet. The result register loads after the key
// compare, RAM read and write-back states; the input is ready again as the
// result register loads, and one item is in work at a time, so a new packet
// is taken only once the previous one has finished its read-modify-write.
// The result register lets a new packet enter while the previous result
// waits; if the receiver stalls, the next item holds in write-back until
// the result register is free.
// Reset clears the fill count and the insert pointer; RAM contents need no
// clearing since only filled slots are searched and a counter-live mask in
// the slot word zeroes stale counters on insert.
// ----------------------------------------------------------------------------
module tcp_flow_congestion_stats_table #(
  parameter int unsigned TABLE_ENTRIES = tcfst_pkg::TABLE_ENTRIES_DEF
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                s_axis_tvalid,
  output logic                                s_axis_tready,
  // src_addr[31:0] dst_addr[63:32] src_port[79:64] dst_port[95:80]
  // cong_state[98:96] packet_bytes[114:99], zero fill above
  input  logic [tcfst_pkg::IN_TDATA_W-1:0]    s_axis_tdata,
  // tracked[0]
  input  logic                                s_axis_tuser,
  output logic                                m_axis_tvalid,
  input  logic                                m_axis_tready,
  // slot[5:0] state_count[37:6] flow_bytes[85:38], zero fill above
  output logic [tcfst_pkg::OUT_TDATA_W-1:0]   m_axis_tdata,
  // status[1:0] evicted[2]
  output logic [tcfst_pkg::OUT_TUSER_W-1:0]   m_axis_tuser
);

  localparam int unsigned SLOT_W    = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
  localparam int unsigned USED_W    = $clog2(TABLE_ENTRIES + 1);
  localparam int unsigned CNT_DEPTH = TABLE_ENTRIES * tcfst_pkg::NUM_STATES;
  localparam int unsigned CNT_AW    = $clog2(CNT_DEPTH);
  localparam logic [SLOT_W-1:0] LAST_SLOT = SLOT_W'(TABLE_ENTRIES - 1);
  localparam logic [USED_W-1:0] FULL_CNT  = USED_W'(TABLE_ENTRIES);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_MATCH = 2'd1;
  localparam logic [1:0] ST_READ  = 2'd2;
  localparam logic [1:0] ST_WB    = 2'd3;

  logic [1:0] state_q, state_d;

  // captured packet
  logic [tcfst_pkg::KEY_W-1:0]   key_q;
  logic [tcfst_pkg::STATE_W-1:0] cst_q;
  logic [tcfst_pkg::LEN_W-1:0]   len_q;
  logic                          drop_q;

  logic [SLOT_W-1:0] next_slot_q;
  logic [USED_W-1:0] used_q;

  logic [tcfst_pkg::KEY_W-1:0] keys_q [TABLE_ENTRIES];
  logic [TABLE_ENTRIES-1:0]    hit_vec_q;

  logic [SLOT_W-1:0] slot_q;
  logic              hit_q;

  // RAMs
  logic [tcfst_pkg::COUNT_W-1:0] cnt_mem [CNT_DEPTH];
  tcfst_pkg::flow_word_t         flow_mem [TABLE_ENTRIES];
  logic [tcfst_pkg::COUNT_W-1:0] cnt_rd_q;
  tcfst_pkg::flow_word_t         flow_rd_q;
  logic                          mem_rd;
  logic                          mem_we;
  logic [CNT_AW-1:0]             cnt_raddr, cnt_waddr_q;
  logic [tcfst_pkg::COUNT_W-1:0] cnt_wdata;
  tcfst_pkg::flow_word_t         flow_wdata;

  // result register
  logic                             out_valid_q;
  logic [tcfst_pkg::OUT_TDATA_W-1:0] out_data_q;
  logic [tcfst_pkg::OUT_TUSER_W-1:0] out_user_q;

  logic accept_in;
  logic out_free;
  logic finish;

  assign s_axis_tready = (state_q == ST_IDLE);
  assign accept_in     = s_axis_tvalid && s_axis_tready;
  assign out_free      = !out_valid_q || m_axis_tready;
  assign finish        = (state_q == ST_WB) && out_free;

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE:  if (accept_in) state_d = ST_MATCH;
      ST_MATCH: state_d = ST_READ;
      ST_READ:  state_d = ST_WB;
      ST_WB:    if (out_free) state_d = ST_IDLE;
      default:  state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  // capture: key is {src_addr, dst_addr, src_port, dst_port}
  always_ff @(posedge clk_i) begin
    if (accept_in) begin
      key_q  <= {s_axis_tdata[31:0], s_axis_tdata[63:32],
                 s_axis_tdata[79:64], s_axis_tdata[95:80]};
      cst_q  <= s_axis_tdata[98:96];
      len_q  <= s_axis_tdata[114:99];
      drop_q <= !s_axis_tuser || (s_axis_tdata[98:96] > tcfst_pkg::MAX_STATE);
    end
  end

  // parallel key compare over filled slots
  always_ff @(posedge clk_i) begin
    if (state_q == ST_MATCH) begin
      for (int i = 0; i < TABLE_ENTRIES; i++) begin
        hit_vec_q[i] <= (USED_W'(i) < used_q) && (keys_q[i] == key_q);
      end
    end
  end

  // keys are unique among filled slots, so the hit vector is one-hot or zero
  logic [SLOT_W-1:0] hit_idx;
  logic              hit_any;
  logic [SLOT_W-1:0] sel_slot;

  always_comb begin
    hit_idx = '0;
    for (int i = 0; i < TABLE_ENTRIES; i++) begin
      if (hit_vec_q[i]) hit_idx = hit_idx | SLOT_W'(i);
    end
    hit_any  = |hit_vec_q;
    sel_slot = hit_any ? hit_idx : next_slot_q;
  end

  // counter address = slot * 5 + state
  assign cnt_raddr = CNT_AW'({sel_slot, 2'b00}) + CNT_AW'(sel_slot) + CNT_AW'(cst_q);
  assign mem_rd    = (state_q == ST_READ);

  always_ff @(posedge clk_i) begin
    if (mem_rd) begin
      slot_q      <= sel_slot;
      hit_q       <= hit_any;
      cnt_waddr_q <= cnt_raddr;
    end
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) cnt_mem[cnt_waddr_q] <= cnt_wdata;
    if (mem_rd) cnt_rd_q <= cnt_mem[cnt_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (mem_we) flow_mem[slot_q] <= flow_wdata;
    if (mem_rd) flow_rd_q <= flow_mem[sel_slot];
  end

  // modify
  logic [tcfst_pkg::NUM_STATES-1:0] st_onehot;
  logic [tcfst_pkg::COUNT_W-1:0]    cnt_base;
  logic [tcfst_pkg::BYTES_W:0]      bytes_sum;
  logic [tcfst_pkg::BYTES_W-1:0]    bytes_new;
  logic [tcfst_pkg::COUNT_W-1:0]    cnt_new;
  logic                             evict;
  logic [tcfst_pkg::OSLOT_W-1:0]    out_slot;

  always_comb begin
    st_onehot = tcfst_pkg::NUM_STATES'(1) << cst_q;
    // counter not written since this slot was filled reads as zero
    cnt_base  = (flow_rd_q.live & st_onehot) != '0 ? cnt_rd_q : '0;
    bytes_sum = {1'b0, flow_rd_q.bytes} + (tcfst_pkg::BYTES_W + 1)'(len_q);
    if (hit_q) begin
      cnt_new   = (cnt_base == tcfst_pkg::COUNT_MAX) ? cnt_base : cnt_base + 1'b1;
      bytes_new = bytes_sum[tcfst_pkg::BYTES_W] ? tcfst_pkg::BYTES_MAX
                                                : bytes_sum[tcfst_pkg::BYTES_W-1:0];
      flow_wdata.live = flow_rd_q.live | st_onehot;
    end else begin
      cnt_new   = tcfst_pkg::COUNT_W'(1);
      bytes_new = tcfst_pkg::BYTES_W'(len_q);
      flow_wdata.live = st_onehot;
    end
    flow_wdata.last_state = cst_q;
    flow_wdata.bytes      = bytes_new;
    cnt_wdata             = cnt_new;
    evict                 = !hit_q && (used_q >= FULL_CNT);
    for (int b = 0; b < tcfst_pkg::OSLOT_W; b++) begin
      out_slot[b] = (b < SLOT_W) ? slot_q[b] : 1'b0;
    end
  end

  assign mem_we = finish && !drop_q;

  always_ff @(posedge clk_i) begin
    if (mem_we && !hit_q) keys_q[slot_q] <= key_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      next_slot_q <= '0;
      used_q      <= '0;
    end else if (mem_we && !hit_q) begin
      next_slot_q <= (slot_q == LAST_SLOT) ? '0 : slot_q + 1'b1;
      if (used_q < FULL_CNT) used_q <= used_q + 1'b1;
    end
  end

  // result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (finish) begin
      out_valid_q <= 1'b1;
    end else if (m_axis_tready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (finish) begin
      if (drop_q) begin
        out_data_q <= '0;
        out_user_q <= {1'b0, tcfst_pkg::STATUS_DROPPED};
      end else begin
        out_data_q <= {2'b00, bytes_new, cnt_new, out_slot};
        out_user_q <= {evict, hit_q ? tcfst_pkg::STATUS_UPDATED
                                    : tcfst_pkg::STATUS_INSERTED};
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = out_data_q;
  assign m_axis_tuser  = out_user_q;

endmodule

[sim/tb_tcp_flow_congestion_stats_table.sv]
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_tcp_flow_congestion_stats_table
// Self-checking bench for the flow congestion statistics table. A directed
// table covers extreme keys, byte lengths, states and drops. It is followed
// by random packets, mostly from a pool of near-identical keys, so that hits,
// inserts and round-robin eviction all occur. Every result item is compared
// to a fixed row's typed report, else to the local flow table of accepted packets.
// ----------------------------------------------------------------------------
module tb_tcp_flow_congestion_stats_table;

  localparam int unsigned SLOTS          = tcfst_pkg::TABLE_ENTRIES_DEF;
  localparam int unsigned RANDOM_PACKETS = 650;
  localparam int unsigned KEY_POOL       = 96;
  localparam int unsigned HOT_KEYS       = 12;
  localparam int unsigned DRAIN_CYCLES   = 20;
  localparam int unsigned MAX_REPORTS    = 10;
  localparam longint unsigned CYCLE_LIMIT = 200000;

  typedef struct packed {
    logic                          tracked;
    logic [tcfst_pkg::ADDR_W-1:0]  src_addr;
    logic [tcfst_pkg::ADDR_W-1:0]  dst_addr;
    logic [tcfst_pkg::PORT_W-1:0]  src_port;
    logic [tcfst_pkg::PORT_W-1:0]  dst_port;
    logic [tcfst_pkg::STATE_W-1:0] cong_state;
    logic [tcfst_pkg::LEN_W-1:0]   packet_bytes;
  } packet_t;

  typedef struct packed {
    tcfst_pkg::status_e            status;
    logic                          evicted;
    logic [tcfst_pkg::OSLOT_W-1:0] slot;
    logic [tcfst_pkg::COUNT_W-1:0] state_count;
    logic [tcfst_pkg::BYTES_W-1:0] flow_bytes;
  } flow_report_t;

  typedef struct {
    packet_t      pkt;
    bit           fixed;
    flow_report_t report;
  } directed_row_t;

  logic                              clk_i;
  logic                              rst_ni;
  logic                              s_axis_tvalid;
  logic                              s_axis_tready;
  logic [tcfst_pkg::IN_TDATA_W-1:0]  s_axis_tdata;
  logic                              s_axis_tuser;
  logic                              m_axis_tvalid;
  logic                              m_axis_tready;
  logic [tcfst_pkg::OUT_TDATA_W-1:0] m_axis_tdata;
  logic [tcfst_pkg::OUT_TUSER_W-1:0] m_axis_tuser;

  tcp_flow_congestion_stats_table #(
    .TABLE_ENTRIES(SLOTS)
  ) dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tuser (s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser)
  );

  // local flow table
  logic [tcfst_pkg::KEY_W-1:0]   flow_key   [SLOTS];
  logic [tcfst_pkg::COUNT_W-1:0] flow_count [SLOTS][tcfst_pkg::NUM_STATES];
  logic [tcfst_pkg::BYTES_W-1:0] flow_total [SLOTS];
  int unsigned                   insert_ptr;
  int unsigned                   filled;

  flow_report_t                flow_reports[$];
  directed_row_t               directed[$];
  logic [tcfst_pkg::KEY_W-1:0] key_pool[KEY_POOL];

  int unsigned     mismatches;
  int unsigned     reports_seen;
  int unsigned     rx_wait;
  bit              tx_burst;
  bit              rx_burst;
  longint unsigned cycles;

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycles++;
    if (cycles >= CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  function automatic flow_report_t account_packet(input packet_t p);
    flow_report_t                r;
    logic [tcfst_pkg::KEY_W-1:0] key;
    logic [tcfst_pkg::BYTES_W:0] sum;
    int                          hit_slot;
    int                          i;
    r = '0;
    r.status = tcfst_pkg::STATUS_DROPPED;
    if (!p.tracked || p.cong_state > tcfst_pkg::MAX_STATE) return r;
    key = {p.src_addr, p.dst_addr, p.src_port, p.dst_port};
    hit_slot = -1;
    for (i = 0; i < filled; i++)
      if (hit_slot < 0 && flow_key[i] == key) hit_slot = i;
    if (hit_slot >= 0) begin
      if (flow_count[hit_slot][p.cong_state] != tcfst_pkg::COUNT_MAX)
        flow_count[hit_slot][p.cong_state] += 1;
      sum = {1'b0, flow_total[hit_slot]} + p.packet_bytes;
      flow_total[hit_slot] = sum[tcfst_pkg::BYTES_W] ? tcfst_pkg::BYTES_MAX
                                                     : sum[tcfst_pkg::BYTES_W-1:0];
      r.status = tcfst_pkg::STATUS_UPDATED;
    end else begin
      hit_slot = insert_ptr;
      r.status = tcfst_pkg::STATUS_INSERTED;
      r.evicted = (filled >= SLOTS);
      flow_key[hit_slot] = key;
      for (i = 0; i < tcfst_pkg::NUM_STATES; i++) flow_count[hit_slot][i] = '0;
      flow_count[hit_slot][p.cong_state] = 1;
      flow_total[hit_slot] = tcfst_pkg::BYTES_W'(p.packet_bytes);
      insert_ptr = (insert_ptr + 1) % SLOTS;
      if (filled < SLOTS) filled++;
    end
    r.slot        = tcfst_pkg::OSLOT_W'(hit_slot);
    r.state_count = flow_count[hit_slot][p.cong_state];
    r.flow_bytes  = flow_total[hit_slot];
    return r;
  endfunction

  function automatic packet_t random_packet();
    packet_t                     p;
    int unsigned                 pick;
    logic [tcfst_pkg::KEY_W-1:0] key;
    pick = $urandom_range(0, 99);
    if (pick < 45)      key = key_pool[$urandom_range(0, HOT_KEYS - 1)];
    else if (pick < 85) key = key_pool[$urandom_range(0, KEY_POOL - 1)];
    else                key = {$urandom, $urandom, $urandom};
    {p.src_addr, p.dst_addr, p.src_port, p.dst_port} = key;
    p.tracked    = 1'b1;
    p.cong_state = tcfst_pkg::STATE_W'($urandom_range(0, 4));
    case ($urandom_range(0, 7))
      0:       p.packet_bytes = '0;
      1:       p.packet_bytes = '1;
      default: p.packet_bytes = tcfst_pkg::LEN_W'($urandom);
    endcase
    // noise: untracked, or a state out of range
    if ($urandom_range(0, 9) == 0) begin
      if ($urandom_range(0, 1) == 0) begin
        p.tracked    = 1'b0;
        p.cong_state = tcfst_pkg::STATE_W'($urandom);
      end else begin
        p.cong_state = tcfst_pkg::STATE_W'($urandom_range(5, 7));
      end
    end
    return p;
  endfunction

  function automatic void add_row(input packet_t p, input bit fixed,
                                  input flow_report_t r);
    directed_row_t row;
    row.pkt    = p;
    row.fixed  = fixed;
    row.report = r;
    directed.push_back(row);
  endfunction

  // Called at a falling edge; returns at the falling edge after acceptance
  // with tvalid still high, so back-to-back items never pulse it low.
  task automatic send_packet(input packet_t p, input bit fixed,
                             input flow_report_t typed);
    int unsigned  gap;
    flow_report_t predicted;
    gap = tx_burst ? 0 : $urandom_range(0, 7);
    if (gap != 0) begin
      s_axis_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= tcfst_pkg::IN_TDATA_W'({p.packet_bytes, p.cong_state, p.dst_port,
                                             p.src_port, p.dst_addr, p.src_addr});
    s_axis_tuser  <= p.tracked;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    predicted = account_packet(p);
    flow_reports.push_back(fixed ? typed : predicted);
    @(negedge clk_i);
  endtask

  initial begin
    m_axis_tready = 1'b0;
    forever begin
      @(negedge clk_i);
      m_axis_tready <= (rx_wait == 0);
    end
  end

  always @(posedge clk_i) begin : result_check
    flow_report_t seen;
    flow_report_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      seen.status      = tcfst_pkg::status_e'(m_axis_tuser[1:0]);
      seen.evicted     = m_axis_tuser[2];
      seen.slot        = m_axis_tdata[5:0];
      seen.state_count = m_axis_tdata[37:6];
      seen.flow_bytes  = m_axis_tdata[85:38];
      if (flow_reports.size() == 0) begin
        mismatches++;
        if (mismatches <= MAX_REPORTS)
          $display("unexpected item: status %0d slot %0d", seen.status, seen.slot);
      end else begin
        want = flow_reports.pop_front();
        if (seen.status !== want.status || seen.evicted !== want.evicted ||
            seen.slot !== want.slot || seen.state_count !== want.state_count ||
            seen.flow_bytes !== want.flow_bytes) begin
          mismatches++;
          if (mismatches <= MAX_REPORTS)
            $display("mismatch: want st %0d ev %0b slot %0d cnt %0d bytes %0d",
                     want.status, want.evicted, want.slot, want.state_count,
                     want.flow_bytes, " / got st %0d ev %0b slot %0d cnt %0d bytes %0d",
                     seen.status, seen.evicted, seen.slot, seen.state_count,
                     seen.flow_bytes);
        end
      end
      reports_seen++;
      if (reports_seen % 40 == 0) rx_burst = ($urandom_range(0, 3) == 0);
      rx_wait = rx_burst ? 0 : $urandom_range(0, 7);
    end else if (rx_wait != 0) begin
      rx_wait--;
    end
  end

  initial begin : stimulus
    flow_report_t dropped;
    flow_report_t none;
    int unsigned  i;
    rst_ni        = 1'b0;
    s_axis_tvalid = 1'b0;
    s_axis_tdata  = '0;
    s_axis_tuser  = 1'b0;
    tx_burst      = 1'b0;
    rx_burst      = 1'b0;
    rx_wait       = 0;
    insert_ptr    = 0;
    filled        = 0;
    none          = '0;
    dropped       = '0;
    dropped.status = tcfst_pkg::STATUS_DROPPED;

    // groups of four keys, each after the first a single bit away from the key before it
    for (i = 0; i < KEY_POOL; i++) begin
      if (i % 4 == 0) begin
        key_pool[i] = {$urandom, $urandom, $urandom};
      end else begin
        key_pool[i] = key_pool[i-1];
        key_pool[i][$urandom_range(0, tcfst_pkg::KEY_W - 1)] ^= 1'b1;
      end
    end

    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 16'h0}, 1'b1,
            flow_report_t'{tcfst_pkg::STATUS_INSERTED, 1'b0, 6'd0, 32'd1, 48'd0});
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 3'd0, 16'hFFFF}, 1'b1,
            flow_report_t'{tcfst_pkg::STATUS_UPDATED, 1'b0, 6'd0, 32'd2, 48'hFFFF});
    add_row(packet_t'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                      3'd4, 16'hFFFF}, 1'b1,
            flow_report_t'{tcfst_pkg::STATUS_INSERTED, 1'b0, 6'd1, 32'd1, 48'hFFFF});
    add_row(packet_t'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                      3'd4, 16'hFFFF}, 1'b1,
            flow_report_t'{tcfst_pkg::STATUS_UPDATED, 1'b0, 6'd1, 32'd2, 48'h1FFFE});
    add_row(packet_t'{1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                      3'd4, 16'hFFFF}, 1'b1, dropped);
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 3'd5, 16'h1}, 1'b1, dropped);
    add_row(packet_t'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                      3'd7, 16'hFFFF}, 1'b1, dropped);
    add_row(packet_t'{1'b0, 32'h0, 32'h0, 16'h0, 16'h0, 3'd6, 16'h0}, 1'b1, dropped);
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 3'd1, 16'h0040}, 1'b0, none);
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 3'd2, 16'h05DC}, 1'b0, none);
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 3'd3, 16'h8000}, 1'b0, none);
    // keys one bit away from the all-zero flow, each in a different field
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0001, 3'd0, 16'h0010}, 1'b0, none);
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h8000, 16'h0, 3'd1, 16'h0020}, 1'b0, none);
    add_row(packet_t'{1'b1, 32'h8000_0000, 32'h0, 16'h0, 16'h0, 3'd2, 16'h0030},
            1'b0, none);
    add_row(packet_t'{1'b1, 32'h0, 32'h0000_0001, 16'h0, 16'h0, 3'd3, 16'h0040},
            1'b0, none);
    add_row(packet_t'{1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 16'hFFFF, 16'hFFFF,
                      3'd3, 16'h04D2}, 1'b0, none);
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0, 3'd4, 16'hFFFF}, 1'b0, none);
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'hFFFF, 3'd0, 16'h0}, 1'b0, none);
    add_row(packet_t'{1'b1, 32'h0, 32'h0, 16'h0, 16'h0001, 3'd4, 16'h0001}, 1'b0, none);

    repeat (5) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    foreach (directed[k])
      send_packet(directed[k].pkt, directed[k].fixed, directed[k].report);

    for (i = 0; i < RANDOM_PACKETS; i++) begin
      if (i % 50 == 0) tx_burst = ($urandom_range(0, 3) == 0);
      send_packet(random_packet(), 1'b0, none);
    end
    s_axis_tvalid <= 1'b0;

    while (flow_reports.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
